[rtl/bis_pkg.sv]
package bis_pkg;
  localparam int MAX_SRC_WIDTH  = 256;
  localparam int MAX_SRC_HEIGHT = 256;
  localparam int FRAC_BITS      = 8;
  localparam int XW = $clog2(MAX_SRC_WIDTH);
  localparam int YW = $clog2(MAX_SRC_HEIGHT);
  localparam int AW = XW + YW;
  localparam int SWW = XW + 1;
  localparam int SHW = YW + 1;
  // quotient width: coord(12) * src(SWW) << FRAC
  localparam int NW = 12 + ((SWW > SHW) ? SWW : SHW) + FRAC_BITS;
  localparam int DW = 13;
  localparam int FW = FRAC_BITS + 1;

  localparam logic [2:0] REG_SRC_W = 3'd0;
  localparam logic [2:0] REG_SRC_H = 3'd1;
  localparam logic [2:0] REG_DST_W = 3'd2;
  localparam logic [2:0] REG_DST_H = 3'd3;
  localparam logic [2:0] REG_MODE  = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIVX, ST_DIVY, ST_RD1, ST_RD2, ST_RD3, ST_RD4, ST_MIXX, ST_MIXY, ST_OUT
  } state_e;

  typedef struct packed {
    logic        start;
    logic [NW-1:0] num;
    logic [DW-1:0] den;
  } div_req_t;
endpackage

[rtl/bis_div.sv]
module bis_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bis_pkg::div_req_t req_i,
  output logic            done_o,
  output logic [bis_pkg::NW-1:0] quot_o
);
  localparam int CW = $clog2(bis_pkg::NW + 1);
  logic [bis_pkg::NW-1:0] q_q, q_d;
  logic [bis_pkg::DW:0]   r_q, r_d;
  logic [bis_pkg::DW-1:0] den_q, den_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic                   run_q, run_d, done_q, done_d;
  logic [bis_pkg::DW:0]   sh;

  always_comb begin
    q_d = q_q; r_d = r_q; den_d = den_q; cnt_d = cnt_q; run_d = run_q; done_d = 1'b0;
    sh = {r_q[bis_pkg::DW-1:0], q_q[bis_pkg::NW-1]};
    if (req_i.start) begin
      q_d = req_i.num; r_d = '0; den_d = req_i.den;
      cnt_d = CW'(bis_pkg::NW); run_d = 1'b1;
    end else if (run_q) begin
      q_d = {q_q[bis_pkg::NW-2:0], 1'b0};
      if (sh >= {1'b0, den_q}) begin
        r_d = sh - {1'b0, den_q}; q_d[0] = 1'b1;
      end else r_d = sh;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        run_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      run_q <= run_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    q_q <= q_d; r_q <= r_d; den_q <= den_d;
  end
  assign done_o = done_q;
  assign quot_o = q_q;
endmodule

[rtl/bis_store.sv]
module bis_store (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [bis_pkg::AW-1:0] waddr_i,
  input  logic [23:0]            wdata_i,
  input  logic [bis_pkg::AW-1:0] raddr_i,
  output logic [23:0]            rdata_o
);
  logic [23:0] mem [1 << bis_pkg::AW];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

[rtl/bilinear_image_scaler.sv]
// Bilinear image scaler over a single-port-read frame store.
// Write items give no result. Queries: two serial divisions, then store reads
// and blend; valid_o is registered from ST_OUT, entered directly when out of
// range, after one tap in nearest mode, after four taps and the blend in bilinear.
// One item at a time; the next may be taken in the strobe cycle. Reset (async,
// active low) restores register defaults; store not cleared; receiver cannot stall.
module bilinear_image_scaler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cmd_i,
  input  logic [11:0] coord_x_i,
  input  logic [11:0] coord_y_i,
  input  logic [7:0]  in_red_i,
  input  logic [7:0]  in_green_i,
  input  logic [7:0]  in_blue_i,
  output logic        valid_o,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o,
  output logic        range_error_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i
);
  localparam int XW = bis_pkg::XW;
  localparam int YW = bis_pkg::YW;
  localparam int FB = bis_pkg::FRAC_BITS;
  localparam int NW = bis_pkg::NW;
  localparam int FW = bis_pkg::FW;

  // configuration
  logic [8:0]  src_w_q, src_h_q;
  logic [12:0] dst_w_q, dst_h_q;
  logic        mode_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= 9'd256; src_h_q <= 9'd256;
      dst_w_q <= 13'd256; dst_h_q <= 13'd256; mode_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bis_pkg::REG_SRC_W: src_w_q <= cfg_data_i[8:0];
        bis_pkg::REG_SRC_H: src_h_q <= cfg_data_i[8:0];
        bis_pkg::REG_DST_W: dst_w_q <= cfg_data_i;
        bis_pkg::REG_DST_H: dst_h_q <= cfg_data_i;
        bis_pkg::REG_MODE:  mode_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // effective source size: 0 acts as 1, saturate at store size
  logic [bis_pkg::SWW-1:0] sw;
  logic [bis_pkg::SHW-1:0] sh;
  always_comb begin
    if (src_w_q == '0) sw = bis_pkg::SWW'(1);
    else if ({4'b0, src_w_q} > 13'(bis_pkg::MAX_SRC_WIDTH))
      sw = bis_pkg::SWW'(bis_pkg::MAX_SRC_WIDTH);
    else sw = bis_pkg::SWW'(src_w_q);
    if (src_h_q == '0) sh = bis_pkg::SHW'(1);
    else if ({4'b0, src_h_q} > 13'(bis_pkg::MAX_SRC_HEIGHT))
      sh = bis_pkg::SHW'(bis_pkg::MAX_SRC_HEIGHT);
    else sh = bis_pkg::SHW'(src_h_q);
  end

  bis_pkg::state_e st_q, st_d;
  logic [11:0] cy_q;
  logic [XW-1:0] xi_q, xn_q;
  logic [YW-1:0] yi_q, yn_q;
  logic [FW-1:0] fx_q, fy_q;
  logic [23:0] p1_q, p2_q, p3_q;
  logic [FB+8:0] top_q [3];
  logic [FB+8:0] bot_q [3];
  logic [7:0] res_q [3];
  logic       err_q, vld_q;

  bis_pkg::div_req_t dreq;
  logic div_done;
  logic [NW-1:0] quot;
  bis_div u_div (.clk_i, .rst_ni, .req_i(dreq), .done_o(div_done), .quot_o(quot));

  logic we;
  logic [bis_pkg::AW-1:0] waddr, raddr;
  logic [23:0] rdata;
  bis_store u_store (.clk_i, .we_i(we), .waddr_i(waddr), .wdata_i({in_red_i, in_green_i,
    in_blue_i}), .raddr_i(raddr), .rdata_o(rdata));

  wire accept = start && !busy;
  assign busy = (st_q != bis_pkg::ST_IDLE);
  assign we = accept && !cmd_i && (coord_x_i < 12'(bis_pkg::MAX_SRC_WIDTH))
              && (coord_y_i < 12'(bis_pkg::MAX_SRC_HEIGHT));
  assign waddr = {coord_y_i[YW-1:0], coord_x_i[XW-1:0]};

  // integer part clamp from divider quotient
  logic [NW-FB-1:0] qi;
  logic [XW-1:0] xi_c;
  logic [YW-1:0] yi_c;
  assign qi = quot[NW-1:FB];
  always_comb begin
    xi_c = (qi >= (NW-FB)'(sw)) ? XW'(sw - 1'b1) : qi[XW-1:0];
    yi_c = (qi >= (NW-FB)'(sh)) ? YW'(sh - 1'b1) : qi[YW-1:0];
  end

  always_comb begin
    st_d = st_q;
    dreq = '0;
    raddr = {yi_q, xi_q};
    unique case (st_q)
      bis_pkg::ST_IDLE: if (accept && cmd_i) begin
        if (coord_x_i >= dst_w_q[11:0] && dst_w_q[12] == 1'b0 ||
            coord_y_i >= dst_h_q[11:0] && dst_h_q[12] == 1'b0)
          st_d = bis_pkg::ST_OUT;
        else begin
          st_d = bis_pkg::ST_DIVX;
          dreq.start = 1'b1;
          dreq.num = NW'({24'(coord_x_i) * 24'(sw), FB'(0)});
          dreq.den = dst_w_q;
        end
      end
      bis_pkg::ST_DIVX: if (div_done) begin
        st_d = bis_pkg::ST_DIVY;
        dreq.start = 1'b1;
        dreq.num = NW'({24'(cy_q) * 24'(sh), FB'(0)});
        dreq.den = dst_h_q;
      end
      bis_pkg::ST_DIVY: if (div_done) st_d = bis_pkg::ST_RD1;
      bis_pkg::ST_RD1: begin
        raddr = {yi_q, xi_q};
        st_d = mode_q ? bis_pkg::ST_RD2 : bis_pkg::ST_RD4;
      end
      bis_pkg::ST_RD2: begin raddr = {yi_q, xn_q}; st_d = bis_pkg::ST_RD3; end
      bis_pkg::ST_RD3: begin raddr = {yn_q, xi_q}; st_d = bis_pkg::ST_RD4; end
      bis_pkg::ST_RD4: begin
        raddr = {yn_q, xn_q};
        st_d = mode_q ? bis_pkg::ST_MIXX : bis_pkg::ST_OUT;
      end
      bis_pkg::ST_MIXX: st_d = bis_pkg::ST_MIXY;
      bis_pkg::ST_MIXY: st_d = bis_pkg::ST_OUT;
      bis_pkg::ST_OUT:  st_d = bis_pkg::ST_IDLE;
      default: st_d = bis_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= bis_pkg::ST_IDLE; vld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      vld_q <= (st_q == bis_pkg::ST_OUT);
    end
  end

  // datapath; rdata is the registered read of raddr
  logic [FW-1:0] one_fw;
  assign one_fw = FW'(1) << FB;
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cy_q <= coord_y_i; err_q <= 1'b1;
      for (int k = 0; k < 3; k++) res_q[k] <= '0;
    end
    if (st_q == bis_pkg::ST_DIVX && div_done) begin
      err_q <= 1'b0;
      xi_q <= xi_c;
      xn_q <= ((bis_pkg::SWW'(xi_c) + 1'b1) < sw) ? xi_c + 1'b1 : xi_c;
      fx_q <= {1'b0, quot[FB-1:0]};
    end
    if (st_q == bis_pkg::ST_DIVY && div_done) begin
      yi_q <= yi_c;
      yn_q <= ((bis_pkg::SHW'(yi_c) + 1'b1) < sh) ? yi_c + 1'b1 : yi_c;
      fy_q <= {1'b0, quot[FB-1:0]};
    end
    if (st_q == bis_pkg::ST_RD2) p1_q <= rdata;
    if (st_q == bis_pkg::ST_RD3) p2_q <= rdata;
    if (st_q == bis_pkg::ST_RD4) begin
      p3_q <= rdata;
      if (!mode_q) begin
        res_q[0] <= rdata[23:16]; res_q[1] <= rdata[15:8]; res_q[2] <= rdata[7:0];
      end
    end
    if (st_q == bis_pkg::ST_MIXX) begin
      for (int k = 0; k < 3; k++) begin
        top_q[k] <= (FB+9)'(p1_q[16-8*k +: 8] * (one_fw - fx_q))
                  + (FB+9)'(p2_q[16-8*k +: 8] * fx_q);
        bot_q[k] <= (FB+9)'(p3_q[16-8*k +: 8] * (one_fw - fx_q))
                  + (FB+9)'(rdata[16-8*k +: 8] * fx_q);
      end
    end
    if (st_q == bis_pkg::ST_MIXY) begin
      for (int k = 0; k < 3; k++)
        res_q[k] <= 8'(((2*FB+9)'(top_q[k] * (one_fw - fy_q))
                      + (2*FB+9)'(bot_q[k] * fy_q)) >> (2*FB));
    end
  end

  assign valid_o = vld_q;
  assign out_red_o = res_q[0];
  assign out_green_o = res_q[1];
  assign out_blue_o = res_q[2];
  assign range_error_o = err_q;
endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  // stall watchdog: cycles with no handshake of any kind
  localparam int STALL_LIMIT = 3000;
  // settle time after the last result
  localparam int DRAIN_CYCLES = 100;
  localparam int ITEMS_PER_PHASE = 110;
  localparam int RAND_PHASES = 8;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       err;
  } pixel_res_t;

  // one row of the directed table; typed rows carry their own expected pixel
  typedef struct {
    bit         cmd;
    bit [11:0]  x;
    bit [11:0]  y;
    bit [7:0]   r;
    bit [7:0]   g;
    bit [7:0]   b;
    bit         typed;
    pixel_res_t res;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        cmd_i;
  logic [11:0] coord_x_i;
  logic [11:0] coord_y_i;
  logic [7:0]  in_red_i;
  logic [7:0]  in_green_i;
  logic [7:0]  in_blue_i;
  logic        valid_o;
  logic [7:0]  out_red_o;
  logic [7:0]  out_green_o;
  logic [7:0]  out_blue_o;
  logic        range_error_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [12:0] cfg_data_i;

  bilinear_image_scaler uut (.*);

  // mirror of the block: registers, frame store and which entries hold data
  logic [8:0]  mir_src_w;
  logic [8:0]  mir_src_h;
  logic [12:0] mir_dst_w;
  logic [12:0] mir_dst_h;
  logic        mir_mode;
  logic [23:0] mir_store [bis_pkg::MAX_SRC_WIDTH*bis_pkg::MAX_SRC_HEIGHT];
  bit          mir_loaded [bis_pkg::MAX_SRC_WIDTH*bis_pkg::MAX_SRC_HEIGHT];

  pixel_res_t pending_pixels[$];
  int         fail_count;
  int         idle_pct;
  int         stall_cycles;

  initial begin
    clk_i = 1'b0;
    forever begin
      #6 clk_i = 1'b1;
      #6 clk_i = 1'b0;
    end
  end

  function automatic int eff_size(input int v, input int max);
    if (v == 0) return 1;
    return (v > max) ? max : v;
  endfunction

  // source tap along one axis: integer part, next tap (edge repeats), fraction
  function automatic void locate_tap(input logic [11:0] d, input int src, input int dst,
                                     output int ti, output int tn, output int tf);
    longint s;
    s = ((longint'(d) * src) << bis_pkg::FRAC_BITS) / dst;
    ti = int'(s >> bis_pkg::FRAC_BITS);
    if (ti >= src) ti = src - 1;
    tf = int'(s & ((1 << bis_pkg::FRAC_BITS) - 1));
    tn = (ti + 1 < src) ? ti + 1 : ti;
  endfunction

  function automatic bit in_dst(input logic [11:0] x, input logic [11:0] y);
    return (x < mir_dst_w) && (y < mir_dst_h);
  endfunction

  function automatic pixel_res_t resample(input logic [11:0] x, input logic [11:0] y);
    pixel_res_t res;
    int xi, xn, fx, yi, yn, fy, sw, sh, one;
    logic [23:0] p1, p2, p3, p4;
    longint top, bot, v;
    res = '0;
    if (!in_dst(x, y)) begin
      res.err = 1'b1;
      return res;
    end
    sw = eff_size(mir_src_w, bis_pkg::MAX_SRC_WIDTH);
    sh = eff_size(mir_src_h, bis_pkg::MAX_SRC_HEIGHT);
    locate_tap(x, sw, mir_dst_w, xi, xn, fx);
    locate_tap(y, sh, mir_dst_h, yi, yn, fy);
    p1 = mir_store[yi*bis_pkg::MAX_SRC_WIDTH + xi];
    p2 = mir_store[yi*bis_pkg::MAX_SRC_WIDTH + xn];
    p3 = mir_store[yn*bis_pkg::MAX_SRC_WIDTH + xi];
    p4 = mir_store[yn*bis_pkg::MAX_SRC_WIDTH + xn];
    if (!mir_mode) begin
      {res.red, res.green, res.blue} = p1;
      return res;
    end
    one = 1 << bis_pkg::FRAC_BITS;
    for (int k = 0; k < 3; k++) begin
      int sft;
      sft = 16 - 8*k;
      top = longint'((p1 >> sft) & 8'hff) * (one - fx) + longint'((p2 >> sft) & 8'hff) * fx;
      bot = longint'((p3 >> sft) & 8'hff) * (one - fx) + longint'((p4 >> sft) & 8'hff) * fx;
      v = (top * (one - fy) + bot * fy) >> (2*bis_pkg::FRAC_BITS);
      if (v > 255) v = 255;
      case (k)
        0: res.red = v[7:0];
        1: res.green = v[7:0];
        default: res.blue = v[7:0];
      endcase
    end
    return res;
  endfunction

  // one item: random gaps, then hold start until the block takes it
  task automatic send_item(input bit cmd, input bit [11:0] x, input bit [11:0] y,
                           input bit [7:0] r, input bit [7:0] g, input bit [7:0] b,
                           input bit typed, input pixel_res_t typed_res);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start      <= 1'b1;
    cmd_i      <= cmd;
    coord_x_i  <= x;
    coord_y_i  <= y;
    in_red_i   <= r;
    in_green_i <= g;
    in_blue_i  <= b;
    do @(posedge clk_i); while (busy);
    if (!cmd) begin
      if (x < bis_pkg::MAX_SRC_WIDTH && y < bis_pkg::MAX_SRC_HEIGHT) begin
        mir_store[y*bis_pkg::MAX_SRC_WIDTH + x]  = {r, g, b};
        mir_loaded[y*bis_pkg::MAX_SRC_WIDTH + x] = 1'b1;
      end
    end else begin
      pending_pixels.push_back(typed ? typed_res : resample(x, y));
    end
  endtask

  task automatic write_pixel(input bit [11:0] x, input bit [11:0] y);
    send_item(1'b0, x, y, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
  endtask

  // load any tap of this query that was never written, so no read hits garbage
  task automatic preload_taps(input logic [11:0] x, input logic [11:0] y);
    int xi, xn, fx, yi, yn, fy, sw, sh;
    int tx[4];
    int ty[4];
    if (!in_dst(x, y)) return;
    sw = eff_size(mir_src_w, bis_pkg::MAX_SRC_WIDTH);
    sh = eff_size(mir_src_h, bis_pkg::MAX_SRC_HEIGHT);
    locate_tap(x, sw, mir_dst_w, xi, xn, fx);
    locate_tap(y, sh, mir_dst_h, yi, yn, fy);
    tx = '{xi, xn, xi, xn};
    ty = '{yi, yi, yn, yn};
    for (int k = 0; k < 4; k++)
      if (!mir_loaded[ty[k]*bis_pkg::MAX_SRC_WIDTH + tx[k]])
        write_pixel(12'(tx[k]), 12'(ty[k]));
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [12:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      bis_pkg::REG_SRC_W: mir_src_w = data[8:0];
      bis_pkg::REG_SRC_H: mir_src_h = data[8:0];
      bis_pkg::REG_DST_W: mir_dst_w = data;
      bis_pkg::REG_DST_H: mir_dst_h = data;
      bis_pkg::REG_MODE:  mir_mode  = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // registers only change with nothing in flight
  task automatic wait_quiet();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_setting(input int sw, input int sh, input int dw, input int dh,
                               input bit mode);
    wait_quiet();
    write_reg(bis_pkg::REG_SRC_W, 13'(sw));
    write_reg(bis_pkg::REG_SRC_H, 13'(sh));
    write_reg(bis_pkg::REG_DST_W, 13'(dw));
    write_reg(bis_pkg::REG_DST_H, 13'(dh));
    write_reg(bis_pkg::REG_MODE, 13'(mode));
    // unknown index, must leave everything alone
    write_reg(3'(bis_pkg::REG_MODE + 1 + $urandom_range(0, 2)), 13'($urandom));
  endtask

  task automatic random_phase();
    bit [11:0] x, y;
    int sw, sh, pick;
    sw = eff_size(mir_src_w, bis_pkg::MAX_SRC_WIDTH);
    sh = eff_size(mir_src_h, bis_pkg::MAX_SRC_HEIGHT);
    for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 65 && mir_dst_w != 0 && mir_dst_h != 0) begin
        x = 12'($urandom_range(0, mir_dst_w - 1));
        y = 12'($urandom_range(0, mir_dst_h - 1));
        preload_taps(x, y);
        send_item(1'b1, x, y, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
      end else if (pick < 80) begin
        // fresh source content inside the image
        write_pixel(12'($urandom_range(0, sw - 1)), 12'($urandom_range(0, sh - 1)));
      end else if (pick < 90) begin
        // wild coordinates: mostly out of range queries
        x = 12'($urandom);
        y = 12'($urandom);
        preload_taps(x, y);
        send_item(1'b1, x, y, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
      end else begin
        // wild writes, most land outside the store and are dropped
        write_pixel(12'($urandom), 12'($urandom));
      end
    end
  endtask

  // output check: every strobe must match the oldest pending pixel
  always @(posedge clk_i) begin
    pixel_res_t want;
    if (rst_ni && valid_o) begin
      if (pending_pixels.size() == 0) begin
        $error("result with nothing pending");
        fail_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_red_o !== want.red) begin
          $error("out_red expected %0d got %0d", want.red, out_red_o);
          fail_count++;
        end
        if (out_green_o !== want.green) begin
          $error("out_green expected %0d got %0d", want.green, out_green_o);
          fail_count++;
        end
        if (out_blue_o !== want.blue) begin
          $error("out_blue expected %0d got %0d", want.blue, out_blue_o);
          fail_count++;
        end
        if (range_error_o !== want.err) begin
          $error("range_error expected %0d got %0d", want.err, range_error_o);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o || (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    stim_row_t  rows[$];
    pixel_res_t err_px;
    int         pcts[4];
    pcts = '{0, 87, 0, 24};
    err_px = '{red: 8'h00, green: 8'h00, blue: 8'h00, err: 1'b1};
    fail_count   = 0;
    stall_cycles = 0;
    idle_pct     = 0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    cmd_i       = 1'b0;
    coord_x_i   = '0;
    coord_y_i   = '0;
    in_red_i    = '0;
    in_green_i  = '0;
    in_blue_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    // reset values of the registers
    mir_src_w = 9'd256;
    mir_src_h = 9'd256;
    mir_dst_w = 13'd256;
    mir_dst_h = 13'd256;
    mir_mode  = 1'b1;
    foreach (mir_loaded[i]) mir_loaded[i] = 1'b0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part, default 256x256 -> 256x256 bilinear
    rows.push_back('{0, 0, 0, 8'h12, 8'h34, 8'h56, 0, '0});
    rows.push_back('{0, 1, 0, 8'hff, 8'hff, 8'hff, 0, '0});
    rows.push_back('{0, 0, 1, 8'h00, 8'h00, 8'h00, 0, '0});
    rows.push_back('{0, 1, 1, 8'hff, 8'h00, 8'hff, 0, '0});
    // zero fraction: the top-left tap comes through unchanged
    rows.push_back('{1, 0, 0, 0, 0, 0, 1, '{8'h12, 8'h34, 8'h56, 1'b0}});
    // bottom-right corner, all taps fold onto the last pixel
    rows.push_back('{0, 255, 255, 8'hff, 8'hff, 8'hff, 0, '0});
    rows.push_back('{1, 255, 255, 0, 0, 0, 1, '{8'hff, 8'hff, 8'hff, 1'b0}});
    // just past the destination edge, and the far corner
    rows.push_back('{1, 256, 0, 0, 0, 0, 1, err_px});
    rows.push_back('{1, 0, 256, 0, 0, 0, 1, err_px});
    rows.push_back('{1, 4095, 4095, 8'hff, 8'hff, 8'hff, 1, err_px});
    // writes outside the store are dropped
    rows.push_back('{0, 4095, 4095, 8'h00, 8'h00, 8'h00, 0, '0});
    rows.push_back('{0, 256, 3, 8'h77, 8'h77, 8'h77, 0, '0});
    rows.push_back('{0, 0, 0, 8'h00, 8'hff, 8'h00, 0, '0});
    rows.push_back('{1, 0, 0, 0, 0, 0, 0, '0});
    foreach (rows[i])
      send_item(rows[i].cmd, rows[i].x, rows[i].y, rows[i].r, rows[i].g, rows[i].b,
                rows[i].typed, rows[i].res);

    // fixed settings with the extremes, then random ones
    for (int p = 0; p < 5 + RAND_PHASES; p++) begin
      case (p)
        0: apply_setting(1, 1, 1, 1, 1'b0);
        1: apply_setting(256, 256, 4096, 4096, 1'b1);
        2: apply_setting(0, 511, 7, 3, 1'b1);       // zero and oversized source
        3: apply_setting(5, 3, 0, 9, 1'b1);         // zero width: all out of range
        4: apply_setting(256, 1, 1, 4096, 1'b0);
        default: apply_setting($urandom_range(1, 16), $urandom_range(1, 16),
                               $urandom_range(1, 40), $urandom_range(1, 40),
                               1'($urandom));
      endcase
      idle_pct = pcts[p % 4];
      random_phase();
    end

    wait_quiet();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
